// ----- hdl/alas_pkg.sv -----
// Package for the alarm annunciator sequencer.
// Holds register indexes, lamp modes and the per-tick control struct; no dependencies.
`timescale 1ns / 1ps

package alas_pkg;

  // Width of a tick counter, its period register and the configuration data.
  localparam int unsigned CNT_W = 8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FLICKER_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD   = 1'b1;

  // Reset values of the period registers.
  localparam logic [CNT_W-1:0] FLICKER_PERIOD_RST = 8'd5;
  localparam logic [CNT_W-1:0] BLINK_PERIOD_RST   = 8'd20;

  // What drives a channel's lamp during one tick.
  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_ON,
    MODE_FLICKER,
    MODE_BLINK
  } lamp_mode_t;

  // Controls shared by all channel lanes for one tick.
  typedef struct packed {
    logic accept;
    logic ack;
    logic clear;
    logic flicker_phase;
    logic blink_phase;
  } alas_tick_t;

endpackage

// ----- hdl/alarm_annunciator_sequencer.sv -----
// Top level of the alarm annunciator sequencer.
// Depends on alas_pkg, alas_phase_gen, alas_lane and alas_out_buf.
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in_       in_valid / in_ready   in_alarm_bits, in_ack_button, in_reset_button
// out_      out_valid / out_ready out_lamp_bits
// cfg_      cfg_wr_en             cfg_index, cfg_wdata
//
// Lamp requests are registered; one tick per cycle while in_ready is high.
// The counters and all channel lanes update in the accept cycle itself.
// A two-entry output stage (output register and skid register) lets one more
// tick enter while a result waits; in_ready drops only when both are full.
// Synchronous active-low reset clears flags, counters and phases and restores
// the period registers to 5 and 20.

module alarm_annunciator_sequencer
  import alas_pkg::*;
#(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHANNELS-1:0]  in_alarm_bits,
  input  logic                 in_ack_button,
  input  logic                 in_reset_button,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHANNELS-1:0]  out_lamp_bits,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  logic [CNT_W-1:0]    flicker_period_r;
  logic [CNT_W-1:0]    blink_period_r;
  logic                accept;
  logic                room;
  logic                flicker_phase;
  logic                blink_phase;
  alas_tick_t          tick;
  logic [CHANNELS-1:0] lamps;

  assign in_ready = room;
  assign accept   = in_valid && room;

  // Period registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flicker_period_r <= FLICKER_PERIOD_RST;
      blink_period_r   <= BLINK_PERIOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FLICKER_PERIOD: flicker_period_r <= cfg_wdata;
        REG_BLINK_PERIOD:   blink_period_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Fast and slow phase generators.
  alas_phase_gen u_flicker (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (accept),
    .period    (flicker_period_r),
    .phase_nxt (flicker_phase)
  );

  alas_phase_gen u_blink (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (accept),
    .period    (blink_period_r),
    .phase_nxt (blink_phase)
  );

  // Controls broadcast to every lane.
  always_comb begin
    tick.accept        = accept;
    tick.ack           = in_ack_button;
    tick.clear         = in_reset_button;
    tick.flicker_phase = flicker_phase;
    tick.blink_phase   = blink_phase;
  end

  // One lane per channel.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    alas_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .tick  (tick),
      .alarm (in_alarm_bits[g]),
      .lamp  (lamps[g])
    );
  end

  // Merge the lane lamps into the result channel.
  alas_out_buf #(
    .CHANNELS (CHANNELS)
  ) u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (accept),
    .lamps         (lamps),
    .room          (room),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_lamp_bits (out_lamp_bits)
  );

endmodule

// ----- hdl/alas_phase_gen.sv -----
// Tick counter and phase toggle for the alarm annunciator sequencer.
// Depends on alas_pkg for the counter width.
`timescale 1ns / 1ps

module alas_phase_gen
  import alas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [CNT_W-1:0] period,
  output logic             phase_nxt
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             phase_r;
  logic             match;

  // The old count is compared with the period; a match wraps and toggles.
  assign match     = (count_r == period);
  assign count_nxt = match ? '0 : count_r + CNT_W'(1);
  assign phase_nxt = phase_r ^ match;

  // Counter and phase move once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= 1'b0;
    end else if (advance) begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ----- hdl/alas_lane.sv -----
// One channel lane of the alarm annunciator sequencer: four flags and the lamp.
// Depends on alas_pkg for lamp modes and the tick control struct.
`timescale 1ns / 1ps

module alas_lane
  import alas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  alas_tick_t tick,
  input  logic       alarm,
  output logic       lamp
);

  logic       active_r, active_nxt;
  logic       flicker_r, flicker_nxt;
  logic       blink_r, blink_nxt;
  logic       steady_r, steady_nxt;
  lamp_mode_t mode;

  // Flag sequence; the order of the tests decides which rule applies.
  always_comb begin
    active_nxt  = active_r;
    flicker_nxt = flicker_r;
    blink_nxt   = blink_r;
    steady_nxt  = steady_r;
    mode        = MODE_OFF;
    priority if (tick.ack || steady_r) begin
      priority if (alarm) begin
        steady_nxt = 1'b1;
        active_nxt = 1'b1;
        mode       = MODE_ON;
      end else if (active_r) begin
        blink_nxt   = 1'b1;
        steady_nxt  = 1'b0;
        flicker_nxt = 1'b0;
        mode        = MODE_BLINK;
      end else begin
        active_nxt  = 1'b0;
        blink_nxt   = 1'b0;
        flicker_nxt = 1'b0;
        mode        = MODE_OFF;
      end
    end else if (!blink_r && (flicker_r || alarm)) begin
      active_nxt  = 1'b1;
      flicker_nxt = 1'b1;
      blink_nxt   = 1'b0;
      steady_nxt  = 1'b0;
      mode        = MODE_FLICKER;
    end else if ((!blink_r && !flicker_r && !alarm) || (blink_r && tick.clear)) begin
      active_nxt  = 1'b0;
      blink_nxt   = 1'b0;
      flicker_nxt = 1'b0;
      mode        = MODE_OFF;
    end else if (alarm) begin
      active_nxt  = 1'b1;
      flicker_nxt = 1'b1;
      blink_nxt   = 1'b0;
      steady_nxt  = 1'b0;
      mode        = MODE_FLICKER;
    end else begin
      blink_nxt   = 1'b1;
      steady_nxt  = 1'b0;
      flicker_nxt = 1'b0;
      mode        = MODE_BLINK;
    end
  end

  // Lamp level from the mode and the phases of this tick.
  always_comb begin
    unique case (mode)
      MODE_OFF:     lamp = 1'b0;
      MODE_ON:      lamp = 1'b1;
      MODE_FLICKER: lamp = tick.flicker_phase;
      MODE_BLINK:   lamp = tick.blink_phase;
      default:      lamp = 1'b0;
    endcase
  end

  // Flags change only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      flicker_r <= 1'b0;
      blink_r   <= 1'b0;
      steady_r  <= 1'b0;
    end else if (tick.accept) begin
      active_r  <= active_nxt;
      flicker_r <= flicker_nxt;
      blink_r   <= blink_nxt;
      steady_r  <= steady_nxt;
    end
  end

endmodule

// ----- hdl/alas_out_buf.sv -----
// Merge stage of the alarm annunciator sequencer: collects the lane lamps into
// an output register backed by a skid register. Depends on alas_pkg.
`timescale 1ns / 1ps

module alas_out_buf
  import alas_pkg::*;
#(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [CHANNELS-1:0] lamps,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHANNELS-1:0] out_lamp_bits
);

  logic                out_valid_r;
  logic [CHANNELS-1:0] out_data_r;
  logic                skid_valid_r;
  logic [CHANNELS-1:0] skid_data_r;
  logic                pop;

  assign pop           = out_valid_r && out_ready;
  assign room          = !skid_valid_r;
  assign out_valid     = out_valid_r;
  assign out_lamp_bits = out_data_r;

  // Control: a new request goes to the output register when it is free or
  // draining, otherwise it parks in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid_r || pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= lamps;
      end else begin
        skid_data_r <= lamps;
      end
    end else if (pop && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

endmodule
